// ----- rtl/core/stsf_pkg.sv -----
// Shared widths and constants of the sine tone sample unit.
// Also holds the Taylor-series sine used to build the quarter-wave table.
// No dependencies.
package stsf_pkg;

    localparam int FREQ_W   = 24;
    localparam int MS_W     = 16;
    localparam int INDEX_W  = 22;
    localparam int RATE_W   = 17;
    localparam int PEAK_W   = 15;
    localparam int RAMP_W   = 9;
    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_AMPLITUDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_PERMILLE  = 2'd2;

    localparam logic [RATE_W-1:0] RATE_RESET = 17'd44100;
    localparam logic [PEAK_W-1:0] PEAK_RESET = 15'd32760;
    localparam logic [RAMP_W-1:0] RAMP_RESET = 9'd50;

    // n_len = floor(rate * ms / 1000) via reciprocal plus one correction
    localparam int NPROD_W  = RATE_W + MS_W;
    localparam int NLEN_W   = 24;
    localparam int RECIP_W  = 24;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 24'd8589934;
    localparam int RECIP_SHIFT = 33;
    localparam int MS_PER_S = 1000;

    localparam int DIVISOR_W = RATE_W + 8;
    localparam int REM_W     = DIVISOR_W + 1;
    localparam int STEPS_PER_STAGE = 4;

    localparam int DEN_W   = RAMP_W + NLEN_W;
    localparam int FIN_W   = 32;
    localparam int FOUT_W  = 34;
    localparam int GREM_W  = 34;
    localparam int GAIN_W  = 17;
    localparam int GQ_BITS = 16;
    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

    localparam int SINE_W = 15;
    localparam int PS_W   = PEAK_W + SINE_W;
    localparam int MAG_SHIFT = 31;
    localparam logic [63:0] PIH_Q30 = 64'd1686629713;

    function automatic logic [SINE_W-1:0] sine_from_x(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] sum;
        logic signed [63:0] v;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + signed'(term);
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        v = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
        if (v > 64'sd32767)
        begin
            v = 64'sd32767;
        end
        return v[SINE_W-1:0];
    endfunction

endpackage

// ----- rtl/core/sine_tone_sample_with_fade_unit.sv -----
// Sine tone sample unit with linear fade envelope: top level.
// Depends on stsf_pkg.
//
// Usage: each request on req_* (note_freq, note_ms, sample_index, last_note)
// yields exactly one result on res_* (sample, in_range, end_of_sequence), in
// request order. Both channels are valid/ready.
// Configuration (sample_rate, peak_amplitude, ramp_permille) is written on
// cfg_we/cfg_index/cfg_data while no request is in flight.
// The phase divider is a restoring divider of 46 + PHASE_BITS steps, four
// steps per register stage; the gain divider runs in parallel.
// Throughput: one request per cycle while res_ready stays high.
// Every stage carries its own valid bit; a stage loads when it is empty or
// when the stage after it moves, so a stalled receiver only freezes the
// occupied stages and requests keep entering until the pipe is full.
// Reset clears all valid bits and loads the default configuration
// (44100, 32760, 50). The sine table is constant logic, no fill pass.
module sine_tone_sample_with_fade_unit #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int PHASE_BITS       = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_ready,
    input  logic [stsf_pkg::FREQ_W-1:0]           note_freq,
    input  logic [stsf_pkg::MS_W-1:0]             note_ms,
    input  logic [stsf_pkg::INDEX_W-1:0]          sample_index,
    input  logic                                  last_note,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output logic signed [stsf_pkg::SAMPLE_W-1:0]  sample,
    output logic                                  in_range,
    output logic                                  end_of_sequence,
    input  logic                                  cfg_we,
    input  logic [stsf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [stsf_pkg::CFG_W-1:0]            cfg_data
);

    localparam int JF_W       = stsf_pkg::FREQ_W + stsf_pkg::INDEX_W;
    localparam int DIV_STEPS  = JF_W + PHASE_BITS;
    localparam int SPS        = stsf_pkg::STEPS_PER_STAGE;
    localparam int DIV_STAGES = (DIV_STEPS + SPS - 1) / SPS;
    localparam int DIV_FIRST  = 3;
    localparam int POST       = DIV_FIRST + DIV_STAGES;
    localparam int NSTAGE     = POST + 5;
    localparam int POS_W      = PHASE_BITS - 2;
    localparam int IDX_W      = $clog2(SINE_TABLE_DEPTH);
    localparam int ROM_DEPTH  = SINE_TABLE_DEPTH + 1;
    localparam int ADDR_W     = $clog2(ROM_DEPTH);
    localparam int PROD_W     = POS_W + IDX_W;
    localparam int MAGP_W     = stsf_pkg::PS_W + stsf_pkg::GAIN_W;

    typedef struct packed {
        logic [stsf_pkg::INDEX_W-1:0]  j;
        logic                          last;
        logic                          in_rng;
        logic                          eos;
        logic [stsf_pkg::NPROD_W-1:0]  np;
        logic [stsf_pkg::NPROD_W+stsf_pkg::RECIP_W-1:0] nm;
        logic [stsf_pkg::NLEN_W-1:0]   n_len;
        logic [JF_W-1:0]               dvd;
        logic [stsf_pkg::REM_W-1:0]    rem;
        logic [PHASE_BITS-1:0]         quot;
        logic [stsf_pkg::DEN_W-1:0]    den;
        logic [stsf_pkg::FIN_W-1:0]    a_in;
        logic [stsf_pkg::FOUT_W-1:0]   a_out;
        logic [stsf_pkg::GREM_W-1:0]   grem;
        logic [stsf_pkg::GQ_BITS-1:0]  gq;
        logic                          gflat;
        logic                          neg;
        logic [ADDR_W-1:0]             addr;
        logic [stsf_pkg::SINE_W-1:0]   s;
        logic [stsf_pkg::GAIN_W-1:0]   gain;
        logic [stsf_pkg::PS_W-1:0]     ps;
        logic [stsf_pkg::SAMPLE_W-1:0] mag;
        logic [stsf_pkg::SAMPLE_W-1:0] smp;
    } pipe_t;

    logic [stsf_pkg::RATE_W-1:0] sample_rate_reg;
    logic [stsf_pkg::PEAK_W-1:0] peak_amplitude_reg;
    logic [stsf_pkg::RAMP_W-1:0] ramp_permille_reg;
    logic [stsf_pkg::DIVISOR_W-1:0] divisor;

    pipe_t             st_reg  [NSTAGE];
    pipe_t             st_next [NSTAGE];
    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] vld_next;
    logic [NSTAGE-1:0] adv;

    logic [stsf_pkg::SINE_W-1:0] sine_rom [ROM_DEPTH];

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_reg    <= stsf_pkg::RATE_RESET;
            peak_amplitude_reg <= stsf_pkg::PEAK_RESET;
            ramp_permille_reg  <= stsf_pkg::RAMP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                stsf_pkg::CFG_SAMPLE_RATE:
                    sample_rate_reg <= cfg_data[stsf_pkg::RATE_W-1:0];
                stsf_pkg::CFG_PEAK_AMPLITUDE:
                    peak_amplitude_reg <= cfg_data[stsf_pkg::PEAK_W-1:0];
                stsf_pkg::CFG_RAMP_PERMILLE:
                    ramp_permille_reg <= cfg_data[stsf_pkg::RAMP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign divisor = {sample_rate_reg, 8'b0};

    for (genvar k = 0; k < ROM_DEPTH; k++)
    begin : g_rom
        localparam logic [63:0] XQ =
            (stsf_pkg::PIH_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
        assign sine_rom[k] = stsf_pkg::sine_from_x(XQ);
    end

    // stage flow control
    always_comb
    begin
        adv[NSTAGE-1] = !vld_reg[NSTAGE-1] || res_ready;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        vld_next[0] = adv[0] ? req_valid : vld_reg[0];
        for (int i = 1; i < NSTAGE; i++)
        begin
            vld_next[i] = adv[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NSTAGE; i++)
        begin
            if (adv[i])
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    for (genvar i = 0; i < NSTAGE; i++)
    begin : g_stage
        if (i == 0)
        begin : g_in
            always_comb
            begin
                st_next[0]      = '0;
                st_next[0].j    = sample_index;
                st_next[0].last = last_note;
                st_next[0].dvd  = JF_W'(note_freq) * JF_W'(sample_index);
                st_next[0].np   = stsf_pkg::NPROD_W'(sample_rate_reg)
                                * stsf_pkg::NPROD_W'(note_ms);
            end
        end
        else if (i == 1)
        begin : g_recip
            always_comb
            begin
                st_next[1]    = st_reg[0];
                st_next[1].nm = (stsf_pkg::NPROD_W + stsf_pkg::RECIP_W)'(st_reg[0].np)
                              * (stsf_pkg::NPROD_W + stsf_pkg::RECIP_W)'(stsf_pkg::RECIP_1000);
            end
        end
        else if (i == 2)
        begin : g_nlen
            always_comb
            begin
                logic [stsf_pkg::NLEN_W-1:0]  q0;
                logic [stsf_pkg::NPROD_W-1:0] rm;
                st_next[2] = st_reg[1];
                q0 = st_reg[1].nm[stsf_pkg::RECIP_SHIFT +: stsf_pkg::NLEN_W];
                rm = st_reg[1].np - stsf_pkg::NPROD_W'(q0)
                   * stsf_pkg::NPROD_W'(stsf_pkg::MS_PER_S);
                st_next[2].n_len = (rm >= stsf_pkg::NPROD_W'(stsf_pkg::MS_PER_S))
                                 ? q0 + 1'b1 : q0;
            end
        end
        else if (i < POST)
        begin : g_div
            localparam int K = i - DIV_FIRST;
            always_comb
            begin
                pipe_t nxt;
                logic [stsf_pkg::REM_W-1:0]   r;
                logic [JF_W-1:0]              dv;
                logic [PHASE_BITS-1:0]        q;
                logic [stsf_pkg::GREM_W-1:0]  gr;
                logic [stsf_pkg::GQ_BITS-1:0] gq;
                nxt = st_reg[i-1];
                r   = nxt.rem;
                dv  = nxt.dvd;
                q   = nxt.quot;
                for (int s = 0; s < SPS; s++)
                begin
                    if (K * SPS + s < DIV_STEPS)
                    begin
                        r  = {r[stsf_pkg::REM_W-2:0], dv[JF_W-1]};
                        dv = {dv[JF_W-2:0], 1'b0};
                        if (r >= stsf_pkg::REM_W'(divisor))
                        begin
                            r = r - stsf_pkg::REM_W'(divisor);
                            q = {q[PHASE_BITS-2:0], 1'b1};
                        end
                        else
                        begin
                            q = {q[PHASE_BITS-2:0], 1'b0};
                        end
                    end
                end
                nxt.rem  = r;
                nxt.dvd  = dv;
                nxt.quot = q;
                if (K == 0)
                begin
                    nxt.den   = stsf_pkg::DEN_W'(ramp_permille_reg)
                              * stsf_pkg::DEN_W'(nxt.n_len);
                    nxt.a_in  = stsf_pkg::FIN_W'(nxt.j)
                              * stsf_pkg::FIN_W'(stsf_pkg::MS_PER_S);
                    nxt.a_out = stsf_pkg::FOUT_W'(nxt.n_len - stsf_pkg::NLEN_W'(nxt.j))
                              * stsf_pkg::FOUT_W'(stsf_pkg::MS_PER_S);
                end
                else if (K == 1)
                begin
                    nxt.in_rng = stsf_pkg::NLEN_W'(nxt.j) < nxt.n_len;
                    nxt.eos    = nxt.last
                              && (stsf_pkg::NLEN_W'(nxt.j) + 1'b1 == nxt.n_len);
                    nxt.gq     = '0;
                    nxt.gflat  = 1'b0;
                    if (stsf_pkg::GREM_W'(nxt.a_in) < stsf_pkg::GREM_W'(nxt.den))
                    begin
                        nxt.grem = stsf_pkg::GREM_W'(nxt.a_in);
                    end
                    else if (stsf_pkg::GREM_W'(nxt.a_out) < stsf_pkg::GREM_W'(nxt.den))
                    begin
                        nxt.grem = stsf_pkg::GREM_W'(nxt.a_out);
                    end
                    else
                    begin
                        nxt.grem  = '0;
                        nxt.gflat = 1'b1;
                    end
                end
                else if (K >= 2 && K < 2 + stsf_pkg::GQ_BITS / SPS)
                begin
                    gr = nxt.grem;
                    gq = nxt.gq;
                    for (int s = 0; s < SPS; s++)
                    begin
                        gr = {gr[stsf_pkg::GREM_W-2:0], 1'b0};
                        if (gr >= stsf_pkg::GREM_W'(nxt.den))
                        begin
                            gr = gr - stsf_pkg::GREM_W'(nxt.den);
                            gq = {gq[stsf_pkg::GQ_BITS-2:0], 1'b1};
                        end
                        else
                        begin
                            gq = {gq[stsf_pkg::GQ_BITS-2:0], 1'b0};
                        end
                    end
                    nxt.grem = gr;
                    nxt.gq   = gq;
                end
                st_next[i] = nxt;
            end
        end
        else if (i == POST)
        begin : g_addr
            always_comb
            begin
                logic [PROD_W-1:0] prod;
                logic [IDX_W-1:0]  idx;
                st_next[i]     = st_reg[i-1];
                st_next[i].neg = st_reg[i-1].quot[PHASE_BITS-1];
                prod = PROD_W'(st_reg[i-1].quot[POS_W-1:0])
                     * PROD_W'(SINE_TABLE_DEPTH);
                idx  = prod[POS_W +: IDX_W];
                st_next[i].addr = st_reg[i-1].quot[PHASE_BITS-2]
                                ? ADDR_W'(SINE_TABLE_DEPTH) - ADDR_W'(idx)
                                : ADDR_W'(idx);
            end
        end
        else if (i == POST + 1)
        begin : g_rom_rd
            always_comb
            begin
                st_next[i]      = st_reg[i-1];
                st_next[i].s    = sine_rom[st_reg[i-1].addr];
                st_next[i].gain = st_reg[i-1].gflat ? stsf_pkg::GAIN_ONE
                                : stsf_pkg::GAIN_W'(st_reg[i-1].gq);
            end
        end
        else if (i == POST + 2)
        begin : g_peak
            always_comb
            begin
                st_next[i]    = st_reg[i-1];
                st_next[i].ps = stsf_pkg::PS_W'(peak_amplitude_reg)
                              * stsf_pkg::PS_W'(st_reg[i-1].s);
            end
        end
        else if (i == POST + 3)
        begin : g_env
            always_comb
            begin
                logic [MAGP_W-1:0] mp;
                st_next[i]     = st_reg[i-1];
                mp             = MAGP_W'(st_reg[i-1].ps) * MAGP_W'(st_reg[i-1].gain);
                st_next[i].mag = mp[stsf_pkg::MAG_SHIFT +: stsf_pkg::SAMPLE_W];
            end
        end
        else
        begin : g_out
            always_comb
            begin
                st_next[i] = st_reg[i-1];
                if (!st_reg[i-1].in_rng)
                begin
                    st_next[i].smp = '0;
                end
                else if (st_reg[i-1].neg)
                begin
                    st_next[i].smp = '0 - st_reg[i-1].mag;
                end
                else
                begin
                    st_next[i].smp = st_reg[i-1].mag;
                end
            end
        end
    end

    assign req_ready       = adv[0];
    assign res_valid       = vld_reg[NSTAGE-1];
    assign sample          = signed'(st_reg[NSTAGE-1].smp);
    assign in_range        = st_reg[NSTAGE-1].in_rng;
    assign end_of_sequence = st_reg[NSTAGE-1].eos;

endmodule

// ----- rtl/core/stsf_checker.sv -----
// Port-level checks for the sine tone sample unit, bound to the top level.
// Depends on stsf_pkg and sine_tone_sample_with_fade_unit.
module stsf_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 req_valid,
    input logic                                 req_ready,
    input logic                                 res_valid,
    input logic                                 res_ready,
    input logic signed [stsf_pkg::SAMPLE_W-1:0] sample,
    input logic                                 in_range,
    input logic                                 end_of_sequence
);

    // result held until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // empty output stage means the whole pipe can move
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> req_ready)
        else $error("request refused with empty output");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !in_range |-> sample == '0 && !end_of_sequence)
        else $error("out-of-range request gave nonzero result");

    a_eos_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && end_of_sequence |-> in_range)
        else $error("end of sequence outside note");

    a_ready_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready |-> req_ready)
        else $error("request refused while output drains");

endmodule

bind sine_tone_sample_with_fade_unit stsf_checker u_stsf_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req_valid),
    .req_ready       (req_ready),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .sample          (sample),
    .in_range        (in_range),
    .end_of_sequence (end_of_sequence)
);
